### design/assert_macros.svh
// assertion helpers used by the checker unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("check failed: ante implies cons");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("check failed: ante implies cons one cycle later");

`endif

### design/dcpc_pkg.sv
package dcpc_pkg;

  // crc-16 polynomial, msb first
  localparam logic [15:0] CrcPoly = 16'h1021;

  // reset values of the configuration registers and of both levels
  localparam logic [7:0] BrightCmdRst   = 8'd1;
  localparam logic [7:0] MaxBrightRst   = 8'd100;
  localparam logic [7:0] DefaultBright  = 8'd50;

  // channel codes carried in the channel byte
  localparam logic [7:0] ChanOne = 8'd1;
  localparam logic [7:0] ChanTwo = 8'd2;

  // positions of the kept bytes inside a packet
  localparam int CmdPos   = 1;
  localparam int ChanPos  = 2;
  localparam int ValuePos = 3;

  typedef enum logic [1:0] {
    ReplyCrcErr   = 2'd0,
    ReplyOverflow = 2'd1,
    ReplyUnknown  = 2'd2,
    ReplyOk       = 2'd3
  } reply_code_e;

  typedef enum logic [1:0] {
    CfgBrightCmd     = 2'd0,
    CfgMaxBright     = 2'd1,
    CfgDefaultBright = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    reply_code_e code;
    logic        last;
    logic [7:0]  lvl_one;
    logic [7:0]  lvl_two;
  } reply_t;

  // one byte of crc-16/xmodem, bitwise form
  function automatic logic [15:0] crc16_upd(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### design/dimmer_command_packet_checker_unit.sv
// order: an accepted byte is held in the byte register and decoded from there; its replies are
//   written into the reply queue and show on the output from that queue
// throughput: one byte per cycle; replies leave one per cycle from a four-entry queue while
//   out_ready_i is high, and the byte register holds while fewer than two queue slots are free
// reset (rst_ni, async, active low): framing, crc and queue cleared, both levels 50,
//   registers back to command 1 and maximum 100
`include "assert_macros.svh"

module dimmer_command_packet_checker_unit #(
  parameter int PACKET_LEN = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [7:0]               cfg_data_i,
  // received bytes
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               rx_byte_i,
  // replies
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output dcpc_pkg::reply_code_e    reply_code_o,
  output logic                     reply_last_o,
  output logic [7:0]               level_one_o,
  output logic [7:0]               level_two_o
);
  import dcpc_pkg::*;

  localparam int PktCntW = $clog2(PACKET_LEN);
  localparam int Depth   = 4;
  localparam int PtrW    = $clog2(Depth);
  localparam int QCntW   = $clog2(Depth + 1);

  // configuration registers
  logic [7:0] bright_cmd_q, max_bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_cmd_q <= BrightCmdRst;
      max_bright_q <= MaxBrightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBrightCmd: bright_cmd_q <= cfg_data_i;
        CfgMaxBright: max_bright_q <= cfg_data_i;
        // default level only matters at reset
        CfgDefaultBright: ;
        default: ;
      endcase
    end
  end

  // input byte register
  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             s1_fire;
  logic [QCntW-1:0] q_cnt_q;

  assign s1_fire    = s1_valid_q && (q_cnt_q <= QCntW'(Depth - 2));
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  // packet state
  logic [15:0]        crc_q, crc_d, crc_next;
  logic [PktCntW-1:0] pos_q, pos_d;
  logic [7:0]         cmd_q, chan_q, value_q;
  logic [7:0]         lvl_one_q, lvl_one_d, lvl_two_q, lvl_two_d;
  logic               is_last;

  assign crc_next = crc16_upd(crc_q, s1_byte_q);
  assign is_last  = (pos_q == PktCntW'(PACKET_LEN - 1));

  // reply decode at the last byte of a packet
  logic [1:0] push_n;
  reply_t     res0, res1;
  logic       ok_val;

  always_comb begin
    crc_d     = crc_q;
    pos_d     = pos_q;
    lvl_one_d = lvl_one_q;
    lvl_two_d = lvl_two_q;
    push_n    = 2'd0;
    ok_val    = (value_q <= max_bright_q);
    if (s1_fire) begin
      crc_d = is_last ? 16'h0000 : crc_next;
      pos_d = is_last ? '0 : pos_q + PktCntW'(1);
      if (is_last && (crc_next == 16'h0000) && (cmd_q == bright_cmd_q) && ok_val) begin
        if (chan_q == ChanOne) begin
          lvl_one_d = value_q;
        end else if (chan_q == ChanTwo) begin
          lvl_two_d = value_q;
        end
      end
    end
    res0 = '{code: ReplyOk, last: 1'b1, lvl_one: lvl_one_d, lvl_two: lvl_two_d};
    res1 = res0;
    if (s1_fire && is_last) begin
      if (crc_next != 16'h0000) begin
        push_n    = 2'd1;
        res0.code = ReplyCrcErr;
      end else if (cmd_q != bright_cmd_q) begin
        push_n    = 2'd2;
        res0.code = ReplyUnknown;
        res0.last = 1'b0;
      end else if (ok_val && (chan_q == ChanOne || chan_q == ChanTwo)) begin
        push_n    = 2'd1;
      end else begin
        push_n    = 2'd2;
        res0.code = ReplyOverflow;
        res0.last = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= '0;
      pos_q     <= '0;
      lvl_one_q <= DefaultBright;
      lvl_two_q <= DefaultBright;
    end else begin
      crc_q     <= crc_d;
      pos_q     <= pos_d;
      lvl_one_q <= lvl_one_d;
      lvl_two_q <= lvl_two_d;
    end
  end

  // kept packet bytes
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      if (pos_q == PktCntW'(CmdPos))   cmd_q   <= s1_byte_q;
      if (pos_q == PktCntW'(ChanPos))  chan_q  <= s1_byte_q;
      if (pos_q == PktCntW'(ValuePos)) value_q <= s1_byte_q;
    end
  end

  // reply queue
  reply_t          q_mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic            pop;

  assign out_valid_o = (q_cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      q_mem_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      q_cnt_q  <= q_cnt_q + QCntW'(push_n) - QCntW'(pop);
    end
  end

  assign reply_code_o = q_mem_q[rd_ptr_q].code;
  assign reply_last_o = q_mem_q[rd_ptr_q].last;
  assign level_one_o  = q_mem_q[rd_ptr_q].lvl_one;
  assign level_two_o  = q_mem_q[rd_ptr_q].lvl_two;

  // checks
  `ASSERT_IMPLIES(a_q_bound, clk_i, rst_ni, 1'b1, q_cnt_q <= QCntW'(Depth))
  `ASSERT_IMPLIES(a_pkt_end_replies, clk_i, rst_ni, s1_fire && is_last, push_n != 2'd0)
  `ASSERT_IMPLIES(a_mid_pkt_silent, clk_i, rst_ni, !(s1_fire && is_last), push_n == 2'd0)
  `ASSERT_NEXT(a_lvl_hold, clk_i, rst_ni, !(s1_fire && is_last),
               $stable(lvl_one_q) && $stable(lvl_two_q))

endmodule
